// File: rtl/core/amt7_pkg.sv
// Shared constants, types and codes for the adaptive mean threshold core.
// No dependencies; all rtl/core files but amt7_res_if and amt7_ram use it.
package amt7_pkg;

    // Window geometry
    localparam int WINDOW     = 7;
    localparam int LINES      = WINDOW - 1;
    localparam int HALF       = WINDOW / 2;
    localparam int AREA       = WINDOW * WINDOW;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int OFFSET_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Datapath widths
    localparam int LINE_WORD_W = LINES * PIX_W;
    localparam int COLSUM_W    = $clog2(WINDOW * PIX_MAX + 1);
    localparam int TOTAL_W     = $clog2(AREA * PIX_MAX + 1);
    localparam int LHS_W       = $clog2(AREA * ((1 << PIX_W) + (1 << (OFFSET_W - 1)))) + 1;

    // Output queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Register reset values
    localparam logic [WIDTH_W-1:0]         WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0]        HEIGHT_RST = HEIGHT_W'(480);
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_MEAN_OFFSET  = 2'd2
    } t_cfg_idx;

    // Position flags of one pixel
    typedef struct packed {
        logic interior;
        logic last;
    } t_tag;

    // Column stage -> window stage
    typedef struct packed {
        logic                vld;
        t_tag                tag;
        logic [COLSUM_W-1:0] colsum;
        logic [PIX_W-1:0]    centre;
    } t_col_item;

    typedef struct packed {
        logic fg;
        logic last;
    } t_res_word;

    typedef struct packed {
        logic      vld;
        t_res_word word;
    } t_res_push;

endpackage

// File: rtl/core/amt7_pix_if.sv
// Pixel input channel: valid/ready handshake with pixel and frame marker.
// Depends on amt7_pkg.
interface amt7_pix_if;
    import amt7_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;

    modport source (output valid, pixel, start_of_frame, input ready);
    modport sink   (input valid, pixel, start_of_frame, output ready);
endinterface

// File: rtl/core/amt7_res_if.sv
// Result output channel: valid/ready handshake with threshold decision.
// Depends on nothing.
interface amt7_res_if;
    logic valid;
    logic ready;
    logic foreground;
    logic last_of_frame;

    modport source (output valid, foreground, last_of_frame, input ready);
    modport sink   (input valid, foreground, last_of_frame, output ready);
endinterface

// File: rtl/core/amt7_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on amt7_pkg.
interface amt7_cfg_if;
    import amt7_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/adaptive_mean_threshold_7x7_core.sv
// Adaptive mean threshold over a 7x7 window: top level.
// Depends on amt7_pkg, the amt7 interfaces, amt7_line, amt7_win, amt7_outq.
//
// Usage
//   i_pix : grey pixels in raster order, one transaction per pixel;
//           start_of_frame marks row 0, column 0 and clears the counters.
//   o_res : one transaction per interior pixel (full 7x7 window inside the
//           frame); foreground = pixel > window mean - mean_offset, done
//           exactly as 49*(pixel + offset) > window sum. Border pixels give
//           no transaction. last_of_frame flags the final interior pixel.
//   i_cfg : index 0 image_width, 1 image_height, 2 mean_offset; write only
//           while idle. Width is clamped to [7, 2048], height to [7, 4096].
// Throughput: one pixel per clock while i_pix.ready is high. The line
//   store is one RAM word per column (six lines side by side), read on
//   accept and written back in the next cycle; a back-to-back hit on
//   the same column is forwarded. Pipeline: a pixel goes through r_s1,
//   r_s2 and r_s3; its result is queued and offered on o_res from the
//   next cycle, behind any older results. Stalls: the queue holds eight
//   results; i_pix.ready drops when queued plus in-flight results fill
//   it. Reset clears counters, window sums and config, not the line store.
module adaptive_mean_threshold_7x7_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    amt7_pix_if.sink    i_pix,
    amt7_cfg_if.sink    i_cfg,
    amt7_res_if.source  o_res
);
    import amt7_pkg::*;

    // Configuration registers
    logic [WIDTH_W-1:0]         r_image_width;
    logic [HEIGHT_W-1:0]        r_image_height;
    logic signed [OFFSET_W-1:0] r_mean_offset;
    logic [WIDTH_W-1:0]         width_eff;
    logic [HEIGHT_W-1:0]        height_eff;

    // Pipeline hookup
    logic                       accept;
    logic                       s1_pending, s3_pending;
    t_col_item                  col_item;
    t_res_push                  push;
    logic [OUTQ_CNT_W-1:0]      q_count;
    logic [OUTQ_CNT_W:0]        committed;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_mean_offset  <= OFFSET_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg.data[HEIGHT_W-1:0];
                CFG_MEAN_OFFSET:  r_mean_offset  <= i_cfg.data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry to what the line store and counters support
    always_comb begin
        priority if (r_image_width < WIDTH_W'(WINDOW)) begin
            width_eff = WIDTH_W'(WINDOW);
        end else if (r_image_width > WIDTH_W'(MAX_WIDTH)) begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            width_eff = r_image_width;
        end
        priority if (r_image_height < HEIGHT_W'(WINDOW)) begin
            height_eff = HEIGHT_W'(WINDOW);
        end else if (r_image_height > HEIGHT_W'(MAX_HEIGHT)) begin
            height_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_image_height;
        end
    end

    // Queue slots already spoken for: queued results plus results in flight
    assign committed = (OUTQ_CNT_W+1)'(q_count) + (OUTQ_CNT_W+1)'(s1_pending)
                     + (OUTQ_CNT_W+1)'(col_item.vld && col_item.tag.interior)
                     + (OUTQ_CNT_W+1)'(s3_pending);

    assign i_pix.ready = (committed < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;

    amt7_line u_line (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_pixel          (i_pix.pixel),
        .i_start_of_frame (i_pix.start_of_frame),
        .i_width          (width_eff),
        .i_height         (height_eff),
        .o_s1_pending     (s1_pending),
        .o_col            (col_item)
    );

    amt7_win u_win (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_col         (col_item),
        .i_mean_offset (r_mean_offset),
        .o_s3_pending  (s3_pending),
        .o_push        (push)
    );

    amt7_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_res   (o_res)
    );

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        committed <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH))
        else $error("more results committed than queue slots");
`endif

endmodule

// File: rtl/core/amt7_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// Read of an address written in the same cycle returns the old data.
module amt7_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/amt7_line.sv
// Raster counters, line store read-modify-write and vertical column sum.
// Depends on amt7_pkg and amt7_ram.
module amt7_line (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [amt7_pkg::PIX_W-1:0]   i_pixel,
    input  logic                         i_start_of_frame,
    input  logic [amt7_pkg::WIDTH_W-1:0] i_width,
    input  logic [amt7_pkg::HEIGHT_W-1:0] i_height,
    output logic                         o_s1_pending,
    output amt7_pkg::t_col_item          o_col
);
    import amt7_pkg::*;

    logic [COL_W-1:0]       r_col, n_col, cur_col;
    logic [ROW_W-1:0]       r_row, n_row, cur_row;
    t_tag                   cur_tag;

    logic                   r_s1_vld;
    logic [COL_W-1:0]       r_s1_addr;
    logic [PIX_W-1:0]       r_s1_pix;
    t_tag                   r_s1_tag;

    logic                   r_fwd_vld;
    logic [COL_W-1:0]       r_fwd_addr;
    logic [LINE_WORD_W-1:0] r_fwd_data;

    logic [LINE_WORD_W-1:0] ram_rd, old_word, new_word;
    logic [COLSUM_W-1:0]    colsum;
    t_col_item              r_s2;

    // Position of the incoming pixel; start of frame forces the origin
    always_comb begin
        cur_col = i_start_of_frame ? '0 : r_col;
        cur_row = i_start_of_frame ? '0 : r_row;
        cur_tag.interior = (cur_row >= ROW_W'(LINES)) && (cur_col >= COL_W'(LINES));
        cur_tag.last = (HEIGHT_W'(cur_row) == i_height - HEIGHT_W'(1)) &&
                       (WIDTH_W'(cur_col) == i_width - WIDTH_W'(1));
        if (WIDTH_W'(cur_col) + WIDTH_W'(1) >= i_width) begin
            n_col = '0;
            if (HEIGHT_W'(cur_row) + HEIGHT_W'(1) >= i_height) begin
                n_row = '0;
            end else begin
                n_row = cur_row + ROW_W'(1);
            end
        end else begin
            n_col = cur_col + COL_W'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_s2.vld  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_vld  <= i_accept;
            r_fwd_vld <= r_s1_vld;
            r_s2.vld  <= r_s1_vld;
        end
    end

    // One word per column holds all stored lines, newest in the low byte
    amt7_ram #(
        .WIDTH (LINE_WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_addr),
        .i_wdata (new_word),
        .i_re    (i_accept),
        .i_raddr (cur_col),
        .o_rdata (ram_rd)
    );

    // Write landing on the same edge as the read: take the written word
    always_comb begin
        old_word = (r_fwd_vld && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : ram_rd;
        new_word = {old_word[LINE_WORD_W-PIX_W-1:0], r_s1_pix};
        colsum   = COLSUM_W'(r_s1_pix);
        for (int k = 0; k < LINES; k++) begin
            colsum = colsum + COLSUM_W'(old_word[k*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_addr <= cur_col;
            r_s1_pix  <= i_pixel;
            r_s1_tag  <= cur_tag;
        end
        r_fwd_addr  <= r_s1_addr;
        r_fwd_data  <= new_word;
        r_s2.tag    <= r_s1_tag;
        r_s2.colsum <= colsum;
        r_s2.centre <= old_word[(HALF-1)*PIX_W +: PIX_W];
    end

    assign o_s1_pending = r_s1_vld && r_s1_tag.interior;
    assign o_col        = r_s2;

`ifndef SYNTH
    a_sof_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_start_of_frame) |=> (r_s1_vld && !r_s1_tag.interior))
        else $error("start of frame pixel tagged as interior");

    a_last_is_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_tag.last) |-> r_s1_tag.interior)
        else $error("last of frame on a border pixel");
`endif

endmodule

// File: rtl/core/amt7_win.sv
// Horizontal window of column sums with window total, centre delay line
// and the integer threshold compare. Depends on amt7_pkg.
module amt7_win (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  amt7_pkg::t_col_item                  i_col,
    input  logic signed [amt7_pkg::OFFSET_W-1:0] i_mean_offset,
    output logic                                 o_s3_pending,
    output amt7_pkg::t_res_push                  o_push
);
    import amt7_pkg::*;

    logic [COLSUM_W-1:0]      r_win [WINDOW];
    logic [TOTAL_W-1:0]       n_total;
    logic [PIX_W-1:0]         r_dly [HALF];

    logic                     r_s3_vld;
    t_tag                     r_s3_tag;
    logic [PIX_W-1:0]         r_s3_centre;
    logic [TOTAL_W-1:0]       r_s3_total;

    logic signed [LHS_W-1:0]  diff, lhs, rhs;

    // Sum after the shift: the new column plus the six newest held columns
    always_comb begin
        n_total = TOTAL_W'(i_col.colsum);
        for (int k = 0; k < WINDOW - 1; k++) begin
            n_total = n_total + TOTAL_W'(r_win[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= '0;
            end
            for (int k = 0; k < HALF; k++) begin
                r_dly[k] <= '0;
            end
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= i_col.vld;
            if (i_col.vld) begin
                r_win[0] <= i_col.colsum;
                for (int k = 1; k < WINDOW; k++) begin
                    r_win[k] <= r_win[k-1];
                end
                r_dly[0] <= i_col.centre;
                for (int k = 1; k < HALF; k++) begin
                    r_dly[k] <= r_dly[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_tag    <= i_col.tag;
        r_s3_centre <= r_dly[HALF-1];
        r_s3_total  <= n_total;
    end

    // AREA*(centre + offset) > window total
    always_comb begin
        diff = LHS_W'($signed({1'b0, r_s3_centre})) + LHS_W'(i_mean_offset);
        lhs  = diff * LHS_W'(AREA);
        rhs  = LHS_W'($signed({1'b0, r_s3_total}));
    end

    assign o_push.vld       = r_s3_vld && r_s3_tag.interior;
    assign o_push.word.fg   = (lhs > rhs);
    assign o_push.word.last = r_s3_tag.last;
    assign o_s3_pending     = o_push.vld;

endmodule

// File: rtl/core/amt7_outq.sv
// Small result queue in front of the output channel; absorbs the results
// still in flight when the receiver stalls. Depends on amt7_pkg.
module amt7_outq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  amt7_pkg::t_res_push              i_push,
    output logic [amt7_pkg::OUTQ_CNT_W-1:0]  o_count,
    amt7_res_if.source                       o_res
);
    import amt7_pkg::*;

    t_res_word               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [OUTQ_CNT_W-1:0]   r_count;
    logic                    pop;

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr_ptr <= (r_wr_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + OUTQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + OUTQ_PTR_W'(1);
            end
            unique case ({i_push.vld, pop})
                2'b10:   r_count <= r_count + OUTQ_CNT_W'(1);
                2'b01:   r_count <= r_count - OUTQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    assign o_res.valid         = (r_count != '0);
    assign o_res.foreground    = r_mem[r_rd_ptr].fg;
    assign o_res.last_of_frame = r_mem[r_rd_ptr].last;
    assign o_count             = r_count;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.vld && !pop) |-> (r_count < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");
`endif

endmodule
